// File: hw/rtl/gga_pkg.sv
// ----------------------------------------------------------------------------
// gga_pkg
// Types, character codes, field numbers and conversion constants shared by
// the GGA sentence position parser.
// ----------------------------------------------------------------------------
package gga_pkg;

    // field numbers (count of commas seen before the field)
    localparam logic [3:0] FIELD_LAT      = 4'd2;
    localparam logic [3:0] FIELD_LAT_HEMI = 4'd3;
    localparam logic [3:0] FIELD_LON      = 4'd4;
    localparam logic [3:0] FIELD_LON_HEMI = 4'd5;
    localparam logic [3:0] FIELD_FIX      = 4'd6;
    localparam logic [3:0] FIELD_SAT      = 4'd7;
    localparam logic [3:0] COMMA_MAX      = 4'd15;
    localparam logic [3:0] COMMAS_OK      = 4'd14;

    // character codes
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    // field character count saturates here
    localparam logic [2:0] CHARS_MAX = 3'd7;

    // conversion constants
    localparam logic [23:0] E7         = 24'd10000000;
    localparam logic [31:0] SAT_E7     = 32'd1800000000;
    localparam logic [29:0] ROUND_HALF = 30'd30;
    // ceil(2^36 / 60): exact floor division by 60 for any 30-bit numerator
    localparam logic [30:0] RECIP_60   = 31'd1145324613;
    localparam int          RECIP_SHIFT = 36;

    // snapshot of a finished coordinate field
    typedef struct packed {
        logic        is_lon;
        logic        mag_ok;
        logic [7:0]  deg;
        logic [6:0]  whole;
        logic [23:0] frac;
        logic [23:0] scale;
    } conv_snap_t;

    // scaled partial products
    typedef struct packed {
        logic        is_lon;
        logic        mag_ok;
        logic [31:0] deg_e7;
        logic [29:0] whole_e7;
        logic [23:0] frac_e7;
    } conv_prod_t;

    // minutes numerator with rounding offset
    typedef struct packed {
        logic        is_lon;
        logic        mag_ok;
        logic [31:0] deg_e7;
        logic [29:0] num;
    } conv_sum_t;

    // minutes divided by sixty
    typedef struct packed {
        logic        is_lon;
        logic        mag_ok;
        logic [31:0] deg_e7;
        logic [24:0] quot;
    } conv_quot_t;

    // 10^n for n in 0..7
    function automatic logic [23:0] pow10(input logic [2:0] n);
        logic [23:0] p;
        case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // saturating decimal shift-in of one digit
    function automatic logic [7:0] sat_dec8(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = 12'(acc) * 12'd10 + 12'(d);
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

endpackage

// File: hw/rtl/gga_sentence_position_parser_unit.sv
// ----------------------------------------------------------------------------
// gga_sentence_position_parser_unit
// Parses a GGA sentence one character a word and returns position, fix
// quality and satellite count once the last character has been taken.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | sentence_byte, last_byte
//  out     | out_valid / out_ready| parse_ok, latitude_e7, longitude_e7,
//          |                      | fix_quality, satellite_count
//
//  One character is taken every cycle while in_ready is high; the result word
//  appears the cycle after the last character is taken.
//  A coordinate is converted by a four-stage pipeline (multiply, add, divide
//  by sixty through a reciprocal multiply, saturate) behind its closing comma.
//  in_ready drops only while a result word waits and out_ready is low.
//  Reset clears all parser state and empties the output register.
//
module gga_sentence_position_parser_unit #(
    parameter int FRAC_DIGITS = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         sentence_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               parse_ok,
    output logic signed [31:0] latitude_e7,
    output logic signed [31:0] longitude_e7,
    output logic [7:0]         fix_quality,
    output logic [7:0]         satellite_count
);
    import gga_pkg::*;

    localparam logic [2:0] FRAC_MAX = 3'(FRAC_DIGITS);

    // parser state
    logic [3:0]  comma_reg,   comma_next;
    logic [2:0]  fcc_reg,     fcc_next;
    logic        dot_seen_reg, dot_seen_next;
    logic        dot_ok_reg,  dot_ok_next;
    logic [7:0]  deg_reg,     deg_next;
    logic [3:0]  tens_reg,    tens_next;
    logic [3:0]  units_reg,   units_next;
    logic [23:0] frac_reg,    frac_next;
    logic [2:0]  fd_reg,      fd_next;
    logic [1:0]  hemi_reg,    hemi_next;
    logic [1:0]  present_reg, present_next;
    logic [31:0] lat_reg,     lat_next;
    logic [31:0] lon_reg,     lon_next;
    logic [7:0]  fix_reg,     fix_next;
    logic [7:0]  sat_reg,     sat_next;

    // conversion pipeline
    conv_snap_t  s1_reg;
    conv_prod_t  s2_reg;
    conv_sum_t   s3_reg;
    conv_quot_t  s4_reg;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    conv_snap_t  snap;
    logic        snap_go;
    logic [47:0] frac_prod;
    logic [60:0] quot_prod;
    logic [32:0] mag_sum;
    logic [31:0] mag_final;

    // output register
    logic        out_valid_reg;
    logic        parse_ok_reg;
    logic [31:0] lat_out_reg, lon_out_reg;
    logic [7:0]  fix_out_reg, sat_out_reg;

    // handshake and character decode
    logic        accept;
    logic        done;
    logic        is_digit;
    logic        is_comma;
    logic        is_dot;
    logic [3:0]  digit;
    logic        ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign done     = accept && last_byte;
    assign is_digit = (sentence_byte >= CHAR_ZERO) && (sentence_byte <= CHAR_NINE);
    assign is_comma = (sentence_byte == CHAR_COMMA);
    assign is_dot   = (sentence_byte == CHAR_DOT);
    assign digit    = is_digit ? sentence_byte[3:0] : 4'd0;

    // snapshot of the coordinate field being closed
    always_comb
    begin
        snap.is_lon = (comma_reg == FIELD_LON);
        snap.mag_ok = (fcc_reg >= 3'd4) && dot_seen_reg && dot_ok_reg;
        snap.deg    = deg_reg;
        snap.whole  = 7'(tens_reg) * 7'd10 + 7'(units_reg);
        snap.frac   = frac_reg;
        snap.scale  = pow10(3'd7 - fd_reg);
    end

    // final stage: add degrees and saturate; a malformed field gives zero
    assign mag_sum   = 33'(s4_reg.deg_e7) + 33'(s4_reg.quot);
    assign mag_final = !s4_reg.mag_ok ? 32'd0 :
                       (mag_sum > 33'(SAT_E7)) ? SAT_E7 : mag_sum[31:0];

    // parser next state
    always_comb
    begin
        comma_next    = comma_reg;
        fcc_next      = fcc_reg;
        dot_seen_next = dot_seen_reg;
        dot_ok_next   = dot_ok_reg;
        deg_next      = deg_reg;
        tens_next     = tens_reg;
        units_next    = units_reg;
        frac_next     = frac_reg;
        fd_next       = fd_reg;
        hemi_next     = hemi_reg;
        present_next  = present_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        fix_next      = fix_reg;
        sat_next      = sat_reg;
        snap_go       = 1'b0;

        // converted coordinate lands in its latch
        if (s4_valid_reg)
        begin
            if (s4_reg.is_lon)
                lon_next = mag_final;
            else
                lat_next = mag_final;
        end

        if (accept)
        begin
            if (is_comma)
            begin
                snap_go = (comma_reg == FIELD_LAT) || (comma_reg == FIELD_LON);
                if (comma_reg != COMMA_MAX)
                    comma_next = comma_reg + 4'd1;
                fcc_next      = 3'd0;
                dot_seen_next = 1'b0;
                dot_ok_next   = 1'b0;
                deg_next      = 8'd0;
                tens_next     = 4'd0;
                units_next    = 4'd0;
                frac_next     = 24'd0;
                fd_next       = 3'd0;
            end
            else
            begin
                case (comma_reg)
                    FIELD_LAT, FIELD_LON:
                    begin
                        present_next = present_reg |
                                       ((comma_reg == FIELD_LAT) ? 2'b01 : 2'b10);
                        if (is_dot && !dot_seen_reg)
                        begin
                            dot_seen_next = 1'b1;
                            dot_ok_next   = (fcc_reg >= 3'd2);
                        end
                        else if (!dot_seen_reg)
                        begin
                            deg_next   = sat_dec8(deg_reg, tens_reg);
                            tens_next  = units_reg;
                            units_next = digit;
                        end
                        else if (fd_reg < FRAC_MAX)
                        begin
                            frac_next = 24'(frac_reg * 24'd10) + 24'(digit);
                            fd_next   = fd_reg + 3'd1;
                        end
                    end
                    FIELD_LAT_HEMI, FIELD_LON_HEMI:
                    begin
                        if (comma_reg == FIELD_LAT_HEMI)
                        begin
                            if (fcc_reg == 3'd0 && (sentence_byte == CHAR_S ||
                                                    sentence_byte == CHAR_W))
                                hemi_next[0] = 1'b1;
                            else
                                hemi_next[0] = 1'b0;
                        end
                        else
                        begin
                            if (fcc_reg == 3'd0 && (sentence_byte == CHAR_S ||
                                                    sentence_byte == CHAR_W))
                                hemi_next[1] = 1'b1;
                            else
                                hemi_next[1] = 1'b0;
                        end
                    end
                    FIELD_FIX:
                    begin
                        if (is_digit)
                            fix_next = sat_dec8(fix_reg, digit);
                    end
                    FIELD_SAT:
                    begin
                        if (is_digit)
                            sat_next = sat_dec8(sat_reg, digit);
                    end
                    default:
                    begin
                    end
                endcase
                if (fcc_reg != CHARS_MAX)
                    fcc_next = fcc_reg + 3'd1;
            end
        end
    end

    // parser state registers, cleared after each sentence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comma_reg    <= '0;
            fcc_reg      <= '0;
            dot_seen_reg <= 1'b0;
            dot_ok_reg   <= 1'b0;
            deg_reg      <= '0;
            tens_reg     <= '0;
            units_reg    <= '0;
            frac_reg     <= '0;
            fd_reg       <= '0;
            hemi_reg     <= '0;
            present_reg  <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            fix_reg      <= '0;
            sat_reg      <= '0;
        end
        else if (done)
        begin
            comma_reg    <= '0;
            fcc_reg      <= '0;
            dot_seen_reg <= 1'b0;
            dot_ok_reg   <= 1'b0;
            deg_reg      <= '0;
            tens_reg     <= '0;
            units_reg    <= '0;
            frac_reg     <= '0;
            fd_reg       <= '0;
            hemi_reg     <= '0;
            present_reg  <= '0;
            lat_reg      <= '0;
            lon_reg      <= '0;
            fix_reg      <= '0;
            sat_reg      <= '0;
        end
        else
        begin
            comma_reg    <= comma_next;
            fcc_reg      <= fcc_next;
            dot_seen_reg <= dot_seen_next;
            dot_ok_reg   <= dot_ok_next;
            deg_reg      <= deg_next;
            tens_reg     <= tens_next;
            units_reg    <= units_next;
            frac_reg     <= frac_next;
            fd_reg       <= fd_next;
            hemi_reg     <= hemi_next;
            present_reg  <= present_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            fix_reg      <= fix_next;
            sat_reg      <= sat_next;
        end
    end

    // conversion pipeline valids, flushed at sentence end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= snap_go;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign frac_prod = s1_reg.frac * s1_reg.scale;
    assign quot_prod = s3_reg.num * RECIP_60;

    // conversion pipeline data
    always_ff @(posedge clk)
    begin
        if (snap_go)
            s1_reg <= snap;

        s2_reg.is_lon   <= s1_reg.is_lon;
        s2_reg.mag_ok   <= s1_reg.mag_ok;
        s2_reg.deg_e7   <= 32'(s1_reg.deg) * 32'(E7);
        s2_reg.whole_e7 <= 30'(s1_reg.whole) * 30'(E7);
        s2_reg.frac_e7  <= frac_prod[23:0];

        s3_reg.is_lon <= s2_reg.is_lon;
        s3_reg.mag_ok <= s2_reg.mag_ok;
        s3_reg.deg_e7 <= s2_reg.deg_e7;
        s3_reg.num    <= s2_reg.whole_e7 + 30'(s2_reg.frac_e7) + ROUND_HALF;

        s4_reg.is_lon <= s3_reg.is_lon;
        s4_reg.mag_ok <= s3_reg.mag_ok;
        s4_reg.deg_e7 <= s3_reg.deg_e7;
        s4_reg.quot   <= quot_prod[RECIP_SHIFT +: 25];
    end

    // result word
    assign ok = (comma_next >= COMMAS_OK) && (present_next == 2'b11);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            parse_ok_reg <= ok;
            lat_out_reg  <= !ok ? 32'd0 : hemi_next[0] ? 32'd0 - lat_next : lat_next;
            lon_out_reg  <= !ok ? 32'd0 : hemi_next[1] ? 32'd0 - lon_next : lon_next;
            fix_out_reg  <= ok ? fix_next : 8'd0;
            sat_out_reg  <= ok ? sat_next : 8'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign parse_ok        = parse_ok_reg;
    assign latitude_e7     = signed'(lat_out_reg);
    assign longitude_e7    = signed'(lon_out_reg);
    assign fix_quality     = fix_out_reg;
    assign satellite_count = sat_out_reg;

endmodule
